FILE: design/rfb_client_message_deframer_assert.svh
// Assertion macros shared by the deframer's checker.
`ifndef RFB_CLIENT_MESSAGE_DEFRAMER_ASSERT_SVH
`define RFB_CLIENT_MESSAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFBCMD_ASSERT_NOW(label, clk, rst_n, cond, expect_now) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (expect_now)) else $error("deframer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFBCMD_ASSERT_NEXT(label, clk, rst_n, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("deframer check failed");

`endif

FILE: design/rfbcmd_pkg.sv
// Types and constants of the RFB client message deframer.
package rfbcmd_pkg;

    // Framing phases.
    typedef enum logic [2:0] {
        PH_HANDSHAKE  = 3'd0,
        PH_IDLE       = 3'd1,
        PH_HDR_COUNT  = 3'd2,
        PH_HDR_LENGTH = 3'd3,
        PH_BODY       = 3'd4
    } phase_t;

    // Event codes reported on event_kind.
    localparam logic [1:0] EV_HANDSHAKE = 2'd0;
    localparam logic [1:0] EV_ENDED     = 2'd1;
    localparam logic [1:0] EV_FRAME     = 2'd2;
    localparam logic [1:0] EV_ERROR     = 2'd3;

    // Client message type bytes.
    localparam logic [7:0] MSG_SET_PIXEL_FORMAT = 8'd0;
    localparam logic [7:0] MSG_SET_ENCODINGS    = 8'd2;
    localparam logic [7:0] MSG_FB_UPDATE_REQ    = 8'd3;
    localparam logic [7:0] MSG_KEY_EVENT        = 8'd4;
    localparam logic [7:0] MSG_POINTER_EVENT    = 8'd5;
    localparam logic [7:0] MSG_CUT_TEXT         = 8'd6;

    // Byte counts that follow each type byte, and of the handshake.
    localparam logic [31:0] LEN_SET_PIXEL_FORMAT = 32'd19;
    localparam logic [31:0] LEN_FB_UPDATE_REQ    = 32'd9;
    localparam logic [31:0] LEN_KEY_EVENT        = 32'd7;
    localparam logic [31:0] LEN_POINTER_EVENT    = 32'd5;
    localparam logic [31:0] LEN_ENCODINGS_HDR    = 32'd3;
    localparam logic [31:0] LEN_CUT_TEXT_HDR     = 32'd7;
    localparam logic [31:0] VERSION_BYTES        = 32'd12;
    localparam logic [31:0] HANDSHAKE_BYTES      = VERSION_BYTES + 32'd1;

    // One result beat travelling from the parser to the output stage.
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] mtype;
    } result_t;

endpackage

FILE: design/rfbcmd_in_stage.sv
// Input register stage of the deframer.
module rfbcmd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] data_byte,
    output logic       byte_stall,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       accept;

    // The held byte moves on whenever the downstream side has room.
    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

FILE: design/rfbcmd_parser.sv
// Framing state and next-state logic of the deframer.
module rfbcmd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data,
    output rfbcmd_pkg::result_t result
);
    import rfbcmd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] gather_reg, gather_next;
    logic        halted_reg, halted_next;
    logic [31:0] remaining_dec;
    logic [31:0] gathered;
    logic [31:0] body_len;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HANDSHAKE;
            remaining_reg <= HANDSHAKE_BYTES;
            type_reg      <= '0;
            gather_reg    <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            type_reg      <= type_next;
            gather_reg    <= gather_next;
            halted_reg    <= halted_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        type_next      = type_reg;
        gather_next    = gather_reg;
        halted_next    = halted_reg;
        res            = '0;

        remaining_dec = (remaining_reg != '0) ? remaining_reg - 32'd1 : '0;
        gathered      = {gather_reg[23:0], data};
        if (phase_reg == PH_HDR_COUNT)
        begin
            body_len = {14'd0, gathered[15:0], 2'b00};
        end
        else
        begin
            body_len = gathered;
        end

        if (step && !halted_reg)
        begin
            case (phase_reg)
                PH_HANDSHAKE:
                begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                        res        = '{valid: 1'b1, kind: EV_HANDSHAKE, mtype: 8'd0};
                    end
                end
                PH_IDLE:
                begin
                    type_next   = data;
                    gather_next = '0;
                    case (data)
                        MSG_SET_PIXEL_FORMAT:
                        begin
                            remaining_next = LEN_SET_PIXEL_FORMAT;
                            phase_next     = PH_BODY;
                        end
                        MSG_FB_UPDATE_REQ:
                        begin
                            remaining_next = LEN_FB_UPDATE_REQ;
                            phase_next     = PH_BODY;
                        end
                        MSG_KEY_EVENT:
                        begin
                            remaining_next = LEN_KEY_EVENT;
                            phase_next     = PH_BODY;
                        end
                        MSG_POINTER_EVENT:
                        begin
                            remaining_next = LEN_POINTER_EVENT;
                            phase_next     = PH_BODY;
                        end
                        MSG_SET_ENCODINGS:
                        begin
                            remaining_next = LEN_ENCODINGS_HDR;
                            phase_next     = PH_HDR_COUNT;
                        end
                        MSG_CUT_TEXT:
                        begin
                            remaining_next = LEN_CUT_TEXT_HDR;
                            phase_next     = PH_HDR_LENGTH;
                        end
                        default:
                        begin
                            halted_next = 1'b1;
                            res         = '{valid: 1'b1, kind: EV_ERROR, mtype: data};
                        end
                    endcase
                end
                PH_HDR_COUNT, PH_HDR_LENGTH:
                begin
                    gather_next    = gathered;
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        if (body_len == '0)
                        begin
                            // Empty payload: the message ends on its last header byte.
                            phase_next     = PH_IDLE;
                            remaining_next = '0;
                            res.valid      = 1'b1;
                            res.kind       = (type_reg == MSG_FB_UPDATE_REQ) ? EV_FRAME
                                                                             : EV_ENDED;
                            res.mtype      = type_reg;
                        end
                        else
                        begin
                            remaining_next = body_len;
                            phase_next     = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    remaining_next = remaining_dec;
                    if (remaining_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                        res.valid  = 1'b1;
                        res.kind   = (type_reg == MSG_FB_UPDATE_REQ) ? EV_FRAME : EV_ENDED;
                        res.mtype  = type_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign result = res;

endmodule

FILE: design/rfbcmd_out_skid.sv
// Output register with a skid entry for the deframer's events.
module rfbcmd_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  rfbcmd_pkg::result_t push,
    output logic               ready,
    output logic               event_valid,
    input  logic               event_stall,
    output logic [1:0]         event_kind,
    output logic [7:0]         message_type
);
    import rfbcmd_pkg::*;

    logic       main_valid_reg;
    logic [1:0] main_kind_reg;
    logic [7:0] main_type_reg;
    logic       skid_valid_reg;
    logic [1:0] skid_kind_reg;
    logic [7:0] skid_type_reg;
    logic       pop;

    // Ready comes straight from a register, so the stall never ripples upstream.
    assign ready        = !skid_valid_reg;
    assign pop          = main_valid_reg && !event_stall;
    assign event_valid  = main_valid_reg;
    assign event_kind   = main_kind_reg;
    assign message_type = main_type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            main_valid_reg <= skid_valid_reg || push.valid;
            skid_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_kind_reg <= skid_kind_reg;
                main_type_reg <= skid_type_reg;
            end
            else
            begin
                main_kind_reg <= push.kind;
                main_type_reg <= push.mtype;
            end
        end
        else if (push.valid)
        begin
            if (main_valid_reg)
            begin
                skid_kind_reg <= push.kind;
                skid_type_reg <= push.mtype;
            end
            else
            begin
                main_kind_reg <= push.kind;
                main_type_reg <= push.mtype;
            end
        end
    end

endmodule

FILE: design/rfb_client_message_deframer.sv
// Top level of the RFB 3.3 client-to-server message deframer.
// This block watches the byte stream that a client sends to an RFB 3.3 server,
// one byte per beat on data_byte. The first thirteen bytes (the 12-byte version
// string and the shared flag) make up the handshake, and the byte that ends it
// raises a handshake event with message_type zero. After that the stream is cut
// into client messages by their type byte: types 0, 3, 4 and 5 have fixed
// lengths, type 2 carries a big-endian 16-bit count of 4-byte entries, and
// type 6 carries a big-endian 32-bit length. Each message raises one event on
// the byte that ends it, a frame update event for type 3 and a message ended
// event for the others; a zero count or zero length ends the message on its last
// header byte. An unknown type byte raises one error event carrying that byte,
// and the block then swallows every byte without events until reset.
// The block takes one byte per clock cycle with no gaps while the skid entry
// of the output register is empty, since each byte is framed in a single
// pass of short logic. A byte is held in an input register, passes through
// the framing logic once the output stage has room, and its event (if any) is
// loaded into the output register or its skid entry. The output register
// has a skid entry, so an event stall on its own does not hold off the byte
// side. Only when a second event arrives while the first one waits does the skid
// entry fill, and the byte side is then held off until the cycle in which the
// waiting event is taken, that cycle included.
module rfb_client_message_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    output logic       event_valid,
    input  logic       event_stall,
    output logic [1:0] event_kind,
    output logic [7:0] message_type
);
    import rfbcmd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_ready;
    logic       step;
    result_t    parsed;

    // A held byte is framed in the cycle that the output stage has room for
    // whatever event it might raise.
    assign step = held_valid && out_ready;

    rfbcmd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .byte_stall (byte_stall),
        .take       (out_ready),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // The framing state advances once for every byte that is stepped through, until it halts.
    rfbcmd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .data   (held_byte),
        .result (parsed)
    );

    // Events land in the output register, or in its skid entry while stalled.
    rfbcmd_out_skid u_out_skid (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (parsed),
        .ready        (out_ready),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .message_type (message_type)
    );

endmodule

FILE: design/rfbcmd_checker.sv
// Port-level checker of the deframer and its bind to the top level.
`include "rfb_client_message_deframer_assert.svh"

module rfbcmd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       event_valid,
    input logic       event_stall,
    input logic [1:0] event_kind,
    input logic [7:0] message_type
);
    import rfbcmd_pkg::*;

    // A stalled event beat holds its contents.
    `RFBCMD_ASSERT_NEXT(a_event_hold, clk, rst_n, event_valid && event_stall, event_valid && $stable(event_kind) && $stable(message_type))

    // The error event is the last beat the block ever sends.
    `RFBCMD_ASSERT_NEXT(a_error_last, clk, rst_n, event_valid && !event_stall && event_kind == EV_ERROR, !event_valid)

    // The handshake event carries a zero type.
    `RFBCMD_ASSERT_NOW(a_handshake_type, clk, rst_n, event_valid && event_kind == EV_HANDSHAKE, message_type == 8'd0)

    // Frame update events come only from type-3 messages.
    `RFBCMD_ASSERT_NOW(a_frame_type, clk, rst_n, event_valid && event_kind == EV_FRAME, message_type == MSG_FB_UPDATE_REQ)

endmodule

bind rfb_client_message_deframer rfbcmd_checker u_rfbcmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .message_type (message_type)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the RFB 3.3 client message deframer.
`timescale 1ns / 100ps

module tb_top;

    import rfbcmd_pkg::*;

    // Half clock period, the receiver's long hold-off, stream size, tail, timeout.
    localparam int unsigned HALF_PERIOD   = 5;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned RANDOM_BYTES  = 1000;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam longint unsigned TIMEOUT_NS = 64'd2_000_000;

    // One event beat as the deframer reports it.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] mtype;
    } deframe_event_t;

    // Shadow framer that predicts the events of the byte stream and checks
    // every event beat that the block hands out against the oldest one.
    class deframe_scoreboard;
        phase_t         cur_phase;
        logic [31:0]    remaining;
        logic [7:0]     cur_type;
        logic [31:0]    gather;
        bit             halted;
        deframe_event_t pending_events[$];
        int unsigned    mismatches;

        function new();
            cur_phase  = PH_HANDSHAKE;
            remaining  = HANDSHAKE_BYTES;
            cur_type   = 8'd0;
            gather     = 32'd0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function void push_event(logic [1:0] kind, logic [7:0] mtype);
            deframe_event_t ev;
            ev.kind  = kind;
            ev.mtype = mtype;
            pending_events.push_back(ev);
        endfunction

        function void close_message();
            cur_phase = PH_IDLE;
            remaining = 32'd0;
            push_event((cur_type == MSG_FB_UPDATE_REQ) ? EV_FRAME : EV_ENDED, cur_type);
        endfunction

        // Advances the shadow framer by one accepted byte.
        function void note_byte(logic [7:0] value);
            logic [31:0] body_len;
            if (halted)
                return;
            case (cur_phase)
                PH_HANDSHAKE:
                begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                    begin
                        cur_phase = PH_IDLE;
                        push_event(EV_HANDSHAKE, 8'd0);
                    end
                end
                PH_IDLE:
                begin
                    cur_type = value;
                    gather   = 32'd0;
                    case (value)
                        MSG_SET_PIXEL_FORMAT:
                        begin
                            remaining = LEN_SET_PIXEL_FORMAT;
                            cur_phase = PH_BODY;
                        end
                        MSG_FB_UPDATE_REQ:
                        begin
                            remaining = LEN_FB_UPDATE_REQ;
                            cur_phase = PH_BODY;
                        end
                        MSG_KEY_EVENT:
                        begin
                            remaining = LEN_KEY_EVENT;
                            cur_phase = PH_BODY;
                        end
                        MSG_POINTER_EVENT:
                        begin
                            remaining = LEN_POINTER_EVENT;
                            cur_phase = PH_BODY;
                        end
                        MSG_SET_ENCODINGS:
                        begin
                            remaining = LEN_ENCODINGS_HDR;
                            cur_phase = PH_HDR_COUNT;
                        end
                        MSG_CUT_TEXT:
                        begin
                            remaining = LEN_CUT_TEXT_HDR;
                            cur_phase = PH_HDR_LENGTH;
                        end
                        default:
                        begin
                            halted = 1'b1;
                            push_event(EV_ERROR, value);
                        end
                    endcase
                end
                PH_HDR_COUNT, PH_HDR_LENGTH:
                begin
                    gather = {gather[23:0], value};
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                    begin
                        if (cur_phase == PH_HDR_COUNT)
                            body_len = {14'd0, gather[15:0], 2'b00};
                        else
                            body_len = gather;
                        if (body_len == 0)
                            close_message();
                        else
                        begin
                            remaining = body_len;
                            cur_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        close_message();
                end
                default:
                    cur_phase = PH_IDLE;
            endcase
        endfunction

        // Compares one event beat with the oldest expectation.
        function void check_event(logic [1:0] kind, logic [7:0] mtype);
            deframe_event_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d type %0d", kind, mtype);
                return;
            end
            want = pending_events.pop_front();
            if (want.kind !== kind || want.mtype !== mtype)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("event mismatch: expected kind %0d type %0d, got kind %0d type %0d",
                             want.kind, want.mtype, kind, mtype);
            end
        endfunction

        function int unsigned outstanding();
            return pending_events.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte = 8'd0;
    logic       event_valid;
    logic       event_stall = 1'b0;
    logic [1:0] event_kind;
    logic [7:0] message_type;

    // Shared between the byte driver and the event-side process. When quiet is
    // set, neither side idles; hold_request asks the event side for one long
    // hold-off, which it counts out on its own and then clears.
    bit          quiet = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned bytes_offered = 0;

    deframe_scoreboard sb;

    rfb_client_message_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .message_type (message_type)
    );

    initial
    begin
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // Both handshakes are observed at the rising edge, where every input and
    // output still holds its value from before the edge. A byte beat feeds the
    // shadow framer, and an event beat is checked against it.
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            sb.note_byte(data_byte);
        if (rst_n && event_valid && !event_stall)
            sb.check_event(event_kind, message_type);
    end

    // Event side: random stall bursts between stall-free runs, one long
    // hold-off on request, and no stalls at all once quiet. Every pass through
    // the loop makes one assignment to the stall and then waits on the clock,
    // so the stall never gets two updates in one time step.
    initial
    begin
        int unsigned span;
        bit          hold;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                event_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (quiet)
            begin
                event_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                hold = ($urandom_range(0, 2) == 0);
                span = hold ? $urandom_range(1, 11) : $urandom_range(1, 20);
                event_stall <= hold;
                repeat (span) @(posedge clk);
            end
        end
    end

    // Payload bytes lean toward the two extremes so both show up often.
    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offers one byte beat, sometimes after a random gap, and returns at the
    // edge where the block takes it.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= value;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_offered++;
    endtask

    // Sends one whole client message. For a set-encodings message size is the
    // entry count, for a cut-text message it is the text length; pad fills the
    // header pad bytes so the block is seen to drop them.
    task automatic send_message(input logic [7:0] mtype, input logic [31:0] size,
                                input logic [7:0] pad);
        int unsigned body_len;
        send_byte(mtype);
        case (mtype)
            MSG_SET_ENCODINGS:
            begin
                send_byte(pad);
                send_byte(size[15:8]);
                send_byte(size[7:0]);
                body_len = 32'({size[15:0], 2'b00});
            end
            MSG_CUT_TEXT:
            begin
                repeat (3) send_byte(pad);
                send_byte(size[31:24]);
                send_byte(size[23:16]);
                send_byte(size[15:8]);
                send_byte(size[7:0]);
                body_len = size;
            end
            MSG_SET_PIXEL_FORMAT: body_len = LEN_SET_PIXEL_FORMAT;
            MSG_FB_UPDATE_REQ:    body_len = LEN_FB_UPDATE_REQ;
            MSG_KEY_EVENT:        body_len = LEN_KEY_EVENT;
            MSG_POINTER_EVENT:    body_len = LEN_POINTER_EVENT;
            default:              body_len = 0;
        endcase
        repeat (body_len) send_byte(content_byte());
    endtask

    // Picks a well-formed message with random content. Sizes stay small; about one
    // in five cut-text messages has an empty payload, and set-encodings ones more often.
    task automatic send_random_message();
        logic [31:0] size;
        size = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 30));
        case ($urandom_range(0, 9))
            0, 1:    send_message(MSG_SET_PIXEL_FORMAT, 32'd0, 8'd0);
            2, 3:    send_message(MSG_FB_UPDATE_REQ, 32'd0, 8'd0);
            4:       send_message(MSG_KEY_EVENT, 32'd0, 8'd0);
            5:       send_message(MSG_POINTER_EVENT, 32'd0, 8'd0);
            6, 7:    send_message(MSG_SET_ENCODINGS, size % 7, content_byte());
            default: send_message(MSG_CUT_TEXT, size, content_byte());
        endcase
    endtask

    // Drops valid and waits until every predicted event has been seen. It
    // always waits for a clock edge before returning so that valid is not raised
    // again in the same time step.
    task automatic wait_drained();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Stimulus: reset, the handshake, a directed pass over every message type and
    // both empty-payload cases, a random stream of well-formed messages with the
    // long hold-off and a full drain in the middle, two larger payloads, a
    // stall-free tail, and finally an unknown type followed by bytes that the
    // halted block must swallow.
    initial
    begin
        string       version;
        logic [7:0]  bad_type;
        bit          held;
        bit          paused;
        sb      = new();
        version = "RFB 003.003\n";
        held    = 1'b0;
        paused  = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Handshake: the 12-byte version string and the shared flag.
        for (int i = 0; i < VERSION_BYTES; i++)
            send_byte(version[i]);
        send_byte(8'h01);

        // Each type; the empty payloads come behind pad bytes of all ones.
        send_message(MSG_SET_PIXEL_FORMAT, 32'd0, 8'd0);
        send_message(MSG_FB_UPDATE_REQ, 32'd0, 8'd0);
        send_message(MSG_KEY_EVENT, 32'd0, 8'd0);
        send_message(MSG_POINTER_EVENT, 32'd0, 8'd0);
        send_message(MSG_SET_ENCODINGS, 32'd0, 8'hFF);
        send_message(MSG_CUT_TEXT, 32'd0, 8'hFF);
        send_message(MSG_SET_ENCODINGS, 32'd1, 8'h00);
        send_message(MSG_CUT_TEXT, 32'd3, 8'h00);

        // Random stream. Partway in, the event side holds off long enough to
        // fill the output stage and stall the byte side; later the sender stops
        // until every event has come out.
        while (bytes_offered < RANDOM_BYTES)
        begin
            if (!held && bytes_offered > 400)
            begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            if (!paused && bytes_offered > 900)
            begin
                paused = 1'b1;
                wait_drained();
            end
            send_random_message();
        end

        // Larger payloads: a count of thirty-three entries, and a length
        // that needs the second length byte, both behind pad bytes of all ones.
        send_message(MSG_SET_ENCODINGS, 32'h0000_0021, 8'hFF);
        send_message(MSG_CUT_TEXT, 32'h0000_0105, 8'hFF);

        // Stall-free tail on both sides.
        quiet = 1'b1;
        repeat (15) send_random_message();

        // Unknown type byte, then bytes that must produce nothing, valid type
        // bytes among them.
        do
            bad_type = 8'($urandom);
        while (bad_type <= MSG_CUT_TEXT && bad_type != 8'd1);
        send_byte(bad_type);
        send_byte(MSG_FB_UPDATE_REQ);
        repeat (15) send_byte(content_byte());

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout far beyond the slowest correct run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
